@@ hdl/ordered_set_table_defines.svh @@
// ----------------------------------------------------------------------------
// ordered_set_table_defines.svh
// Assertion macros for the ordered set table checker.
// ----------------------------------------------------------------------------
`ifndef ORDERED_SET_TABLE_DEFINES_SVH
`define ORDERED_SET_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is held
`define OST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered_set_table: check failed");

// Next-cycle implication, sampled on clk, off while reset is held
`define OST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered_set_table: check failed");

`endif

@@ hdl/ost_pkg.sv @@
// ----------------------------------------------------------------------------
// ost_pkg
// Types and codes shared by the ordered set table modules.
// ----------------------------------------------------------------------------
package ost_pkg;

  localparam int KEY_W = 32;
  localparam int POS_W = 7;
  localparam int CNT_OUT_W = 8;

  // Request codes
  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_DEL  = 2'd1,
    ACT_FIND = 2'd2,
    ACT_NONE = 2'd3
  } ost_action_t;

  // Result codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_PRESENT = 2'd2,
    ST_ABSENT  = 2'd3
  } ost_status_t;

  // Request sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_LOCATE,
    S_APPLY,
    S_EMIT
  } ost_state_t;

  // Command broadcast along the cell row
  typedef struct packed {
    logic             capture;
    logic             shift;
    logic             load;
    logic [KEY_W-1:0] key;
  } ost_cmd_t;

endpackage

@@ hdl/ost_cell.sv @@
// ----------------------------------------------------------------------------
// ost_cell
// One table slot: holds a key, compares it against the request key and
// takes its upper neighbor's key when a delete closes the gap, or the request key on an add.
// ----------------------------------------------------------------------------
module ost_cell #(
  parameter int CAPACITY = 128,
  parameter int INDEX    = 0
) (
  input  logic                             clk,
  input  ost_pkg::ost_cmd_t                cmd,
  input  logic [$clog2(CAPACITY)-1:0]      pos,
  input  logic [$clog2(CAPACITY+1)-1:0]    used,
  input  logic [ost_pkg::KEY_W-1:0]        next_key,
  output logic [ost_pkg::KEY_W-1:0]        key,
  output logic                             hit
);
  import ost_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY+1);
  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic             hit_r, hit_nxt;
  logic             occupied;

  assign occupied = (MY_IDX < used);

  // Slot update: close the gap on delete, append on add
  always_comb begin
    key_nxt = key_r;
    if (cmd.shift && (MY_IDX >= CNT_W'(pos))) begin
      key_nxt = next_key;
    end
    if (cmd.load && (MY_IDX == used)) begin
      key_nxt = cmd.key;
    end
  end

  // Match flag, captured once per request
  always_comb begin
    hit_nxt = hit_r;
    if (cmd.capture) begin
      hit_nxt = occupied && (key_r == cmd.key);
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    hit_r <= hit_nxt;
  end

  assign key = key_r;
  assign hit = hit_r;

endmodule

@@ hdl/ordered_set_table.sv @@
// Flow: after an input transfer a request passes the match, locate, apply and emit
//   states before its result shows on out_valid, later while out_ready holds it back.
// No new request is taken before the result is emitted, since the compare, one-hot
//   encode and update pass over the cell row; an idle action code leaves the sequencer idle.
// Reset: synchronous, active low; clears the key count, the sequencer and out_valid.
//   Stored keys are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// ordered_set_table
// Insertion-ordered set of distinct 32-bit keys kept in a row of cells.
// ----------------------------------------------------------------------------
module ordered_set_table #(
  parameter int CAPACITY = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic signed [31:0] in_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [6:0]  out_position,
  output logic [7:0]  out_count
);
  import ost_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY+1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  ost_state_t state_r, state_nxt;

  // Request and result registers
  ost_action_t        act_r, act_nxt;
  logic [KEY_W-1:0]   req_key_r, req_key_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic               found_r, found_nxt;
  ost_status_t        res_status_r, res_status_nxt;
  logic [IDX_W-1:0]   res_pos_r, res_pos_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic [CNT_OUT_W-1:0] out_count_r, out_count_nxt;

  ost_cmd_t           cmd;
  logic [KEY_W-1:0]   cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_hit;
  logic               in_xfer;
  logic               out_free;
  logic               is_full;
  logic [IDX_W-1:0]   enc_pos;
  logic [IDX_W+POS_W-1:0]     pos_wide;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_wide;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign is_full  = (used_r == FULL_CNT);

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] nbr_key;
    if (i == CAPACITY-1) begin : g_last
      assign nbr_key = '0;
    end else begin : g_mid
      assign nbr_key = cell_key[i+1];
    end
    ost_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .pos      (pos_r),
      .used     (used_r),
      .next_key (nbr_key),
      .key      (cell_key[i]),
      .hit      (cell_hit[i])
    );
  end

  // One-hot to index: keys are distinct, so at most one cell hits
  always_comb begin
    enc_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_hit[i]) begin
        enc_pos = enc_pos | IDX_W'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && (ost_action_t'(in_action) != ACT_NONE)) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH:  state_nxt = S_LOCATE;
      S_LOCATE: state_nxt = S_APPLY;
      S_APPLY:  state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Handshake and cell commands
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.shift   = 1'b0;
    cmd.load    = 1'b0;
    cmd.key     = req_key_r;
    case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_MATCH: cmd.capture = 1'b1;
      S_APPLY: begin
        cmd.shift = (act_r == ACT_DEL) && found_r;
        cmd.load  = (act_r == ACT_ADD) && !is_full && !found_r;
      end
      default: begin
      end
    endcase
  end

  // Request decode and set bookkeeping
  always_comb begin
    act_nxt        = act_r;
    req_key_nxt    = req_key_r;
    used_nxt       = used_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    if (in_xfer) begin
      act_nxt     = ost_action_t'(in_action);
      req_key_nxt = in_key;
    end
    if (state_r == S_LOCATE) begin
      pos_nxt   = enc_pos;
      found_nxt = |cell_hit;
    end
    if (state_r == S_APPLY) begin
      res_pos_nxt = '0;
      case (act_r)
        ACT_ADD: begin
          if (is_full) begin
            res_status_nxt = ST_FULL;
          end else if (found_r) begin
            res_status_nxt = ST_PRESENT;
          end else begin
            res_status_nxt = ST_OK;
            res_pos_nxt    = IDX_W'(used_r);
            used_nxt       = used_r + CNT_W'(1);
          end
        end
        ACT_DEL: begin
          if (found_r) begin
            res_status_nxt = ST_OK;
            res_pos_nxt    = pos_r;
            used_nxt       = used_r - CNT_W'(1);
          end else begin
            res_status_nxt = ST_ABSENT;
          end
        end
        default: begin
          if (found_r) begin
            res_status_nxt = ST_OK;
            res_pos_nxt    = pos_r;
          end else begin
            res_status_nxt = ST_ABSENT;
          end
        end
      endcase
    end
  end

  // Output register, masked to the field widths
  assign pos_wide = {{POS_W{1'b0}}, res_pos_r};
  assign cnt_wide = {{CNT_OUT_W{1'b0}}, used_r};

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == S_EMIT) && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_pos_nxt    = pos_wide[POS_W-1:0];
      out_count_nxt  = cnt_wide[CNT_OUT_W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    req_key_r    <= req_key_nxt;
    pos_r        <= pos_nxt;
    found_r      <= found_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_pos_r;
  assign out_count    = out_count_r;

endmodule

@@ hdl/ost_checker.sv @@
// ----------------------------------------------------------------------------
// ost_checker
// Port-level checks on the ordered set table, bound to the top level.
// ----------------------------------------------------------------------------
`include "ordered_set_table_defines.svh"

module ost_checker #(
  parameter int CAPACITY = 128
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic signed [31:0] in_key,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [6:0]  out_position,
  input logic [7:0]  out_count
);
  import ost_pkg::*;

  logic [33:0] in_payload;
  logic [16:0] out_payload;
  logic        out_ok;

  assign in_payload  = {in_action, in_key};
  assign out_payload = {out_status, out_position, out_count};
  assign out_ok      = out_valid && (out_status == ST_OK);

  // A waiting request keeps its payload
  `OST_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_payload))

  // A stalled result keeps its payload
  `OST_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

  // Failed requests report position zero
  `OST_ASSERT_IMP(a_fail_pos_zero, out_valid && (out_status != ST_OK), out_position == 7'd0)

  // Key count never exceeds the table size
  `OST_ASSERT_IMP(a_count_bound, out_valid, (CAPACITY > 255) || (int'(out_count) <= CAPACITY))

  // A successful position is no greater than the key count
  `OST_ASSERT_IMP(a_pos_in_range, out_ok && (CAPACITY <= 128), out_position <= out_count)

endmodule

bind ordered_set_table ost_checker #(.CAPACITY(CAPACITY)) u_ost_checker (.*);
